// File: src/crrg_pkg.sv
// ----------------------------------------------------------------------------
// crrg_pkg
// Shared types and constants of the counter reservation and replay guard:
// request and status codes, pending reservation kinds, block sizes and the
// decision record passed from the engine to the result register.
// ----------------------------------------------------------------------------
package crrg_pkg;

   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned EPOCH_W   = 32;
   localparam int unsigned OP_W      = 3;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_W     = 32;

   // Transmit reservation step and the highest bound that can still grow by it
   localparam logic [VALUE_W-1:0] TX_BLOCK = VALUE_W'(1024);
   localparam logic [VALUE_W-1:0] TX_LIMIT = {VALUE_W{1'b1}} - TX_BLOCK;

   // Replay reservation step, a power of two so alignment is a mask
   localparam int unsigned        REPLAY_LOG2  = 10;
   localparam logic [VALUE_W-1:0] REPLAY_BLOCK = VALUE_W'(1) << REPLAY_LOG2;
   localparam logic [VALUE_W-1:0] REPLAY_MASK  = REPLAY_BLOCK - VALUE_W'(1);
   // Largest multiple of the replay block
   localparam logic [VALUE_W-1:0] REPLAY_TOP   = ~REPLAY_MASK;

   typedef enum logic [OP_W-1:0] {
      OP_TAKE_TX      = 3'd0,
      OP_SUBMIT_RX    = 3'd1,
      OP_PERSIST_DONE = 3'd2,
      OP_PERSIST_FAIL = 3'd3,
      OP_LOAD_TX      = 3'd4,
      OP_LOAD_REPLAY  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_TX_ISSUED      = 3'd0,
      ST_REFUSED        = 3'd1,
      ST_RX_ACCEPTED    = 3'd2,
      ST_RX_REJECTED    = 3'd3,
      ST_PERSIST_TX     = 3'd4,
      ST_PERSIST_REPLAY = 3'd5,
      ST_ACK            = 3'd6,
      ST_EXHAUSTED      = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      KIND_IDLE   = 2'd0,
      KIND_TX     = 2'd1,
      KIND_REPLAY = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROVISIONED = 1'b0,
      CSR_CRED_EPOCH  = 1'b1
   } csr_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] counter;
      logic [EPOCH_W-1:0] epoch;
      logic [VALUE_W-1:0] persist_bound;
   } result_type;

endpackage

// File: src/counter_reserve_replay_guard_top.sv
// ----------------------------------------------------------------------------
// counter_reserve_replay_guard_top
// Transmit counter reservation and receive anti-replay guard.
// ----------------------------------------------------------------------------
// Each request item gives exactly one response item. An item is registered on
// acceptance in the input register, decided by the engine (a few 64-bit
// compares and one add against the stored counters) as it moves on, and its
// response lands in the output register that drives rsp_valid; a stalled
// response keeps the next item waiting in the input register. The block
// takes one item every cycle as long as the response side drains.
// The engine updates its counters in the same cycle it decides, so an item
// always sees the state left by the item just before it. Only one persist is
// pending at a time; while one is, requests other than persist done or
// failed are answered refused. Write the csr registers only while idle.
// ----------------------------------------------------------------------------
module counter_reserve_replay_guard_top
   import crrg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [VALUE_W-1:0]   req_value,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [VALUE_W-1:0]   rsp_counter_out,
   output logic [EPOCH_W-1:0]   rsp_epoch_out,
   output logic [VALUE_W-1:0]   rsp_persist_bound,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic               in_valid_ff;
   logic [OP_W-1:0]    in_op_ff;
   logic [VALUE_W-1:0] in_value_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff;
   result_type         decision;
   logic               provisioned_ff;
   logic [EPOCH_W-1:0] cred_epoch_ff;
   logic               advance;

   // Move the registered item into the result register when it has room
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         provisioned_ff <= 1'b0;
         cred_epoch_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROVISIONED: provisioned_ff <= csr_wdata[0];
            CSR_CRED_EPOCH:  cred_epoch_ff  <= csr_wdata[EPOCH_W-1:0];
            default:         provisioned_ff <= provisioned_ff;
         endcase
      end
   end

   // Input register: hold the item until the engine takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff    <= req_op;
         in_value_ff <= req_value;
      end
   end

   crrg_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .op          (in_op_ff),
      .value       (in_value_ff),
      .provisioned (provisioned_ff),
      .cred_epoch  (cred_epoch_ff),
      .result      (decision)
   );

   // Result register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= decision;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_counter_out   = rsp_ff.counter;
   assign rsp_epoch_out     = rsp_ff.epoch;
   assign rsp_persist_bound = rsp_ff.persist_bound;

endmodule

// File: src/crrg_engine.sv
// ----------------------------------------------------------------------------
// crrg_engine
// Counter state and the combinational decision for each item: transmit counter
// issue, receive admission against the high-water mark, completion of the
// single pending persist, and loading of the transmit and replay bounds.
// ----------------------------------------------------------------------------
module crrg_engine
   import crrg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [OP_W-1:0]    op,
   input  logic [VALUE_W-1:0] value,
   input  logic               provisioned,
   input  logic [EPOCH_W-1:0] cred_epoch,
   output result_type         result
);

   logic [VALUE_W-1:0] tx_next_ff, tx_next_in;
   logic [VALUE_W-1:0] tx_bound_ff, tx_bound_in;
   logic [VALUE_W-1:0] replay_bound_ff, replay_bound_in;
   logic [VALUE_W-1:0] mark_ff, mark_in;
   logic               mark_valid_ff, mark_valid_in;
   kind_type           kind_ff, kind_in;
   logic [VALUE_W-1:0] pend_bound_ff, pend_bound_in;
   logic [VALUE_W-1:0] pend_counter_ff, pend_counter_in;
   logic               exhausted_ff, exhausted_in;
   logic               busy;

   assign busy = (kind_ff != KIND_IDLE);

   // Decide the result and the next state for the item at hand
   always_comb begin
      tx_next_in      = tx_next_ff;
      tx_bound_in     = tx_bound_ff;
      replay_bound_in = replay_bound_ff;
      mark_in         = mark_ff;
      mark_valid_in   = mark_valid_ff;
      kind_in         = kind_ff;
      pend_bound_in   = pend_bound_ff;
      pend_counter_in = pend_counter_ff;
      exhausted_in    = exhausted_ff;
      result          = '{status: ST_REFUSED, counter: '0, epoch: '0, persist_bound: '0};

      if (provisioned) begin
         case (op)
            OP_TAKE_TX: begin
               if (busy) begin
                  result.status = ST_REFUSED;
               end else if (exhausted_ff) begin
                  result.status = ST_EXHAUSTED;
               end else if (tx_next_ff < tx_bound_ff) begin
                  result.status  = ST_TX_ISSUED;
                  result.counter = tx_next_ff;
                  result.epoch   = cred_epoch;
                  tx_next_in     = tx_next_ff + VALUE_W'(1);
               end else if (tx_bound_ff > TX_LIMIT) begin
                  result.status = ST_EXHAUSTED;
                  exhausted_in  = 1'b1;
               end else begin
                  // Range used up: ask for the next reservation
                  kind_in              = KIND_TX;
                  pend_bound_in        = tx_bound_ff + TX_BLOCK;
                  pend_counter_in      = '0;
                  result.status        = ST_PERSIST_TX;
                  result.persist_bound = tx_bound_ff + TX_BLOCK;
               end
            end
            OP_SUBMIT_RX: begin
               if (busy) begin
                  result.status = ST_REFUSED;
               end else if (mark_valid_ff && (value <= mark_ff)) begin
                  result.status = ST_RX_REJECTED;
               end else if (value < replay_bound_ff) begin
                  result.status = ST_RX_ACCEPTED;
                  mark_in       = value;
                  mark_valid_in = 1'b1;
               end else if (value >= REPLAY_TOP) begin
                  result.status = ST_EXHAUSTED;
               end else begin
                  // Hold the counter until the next aligned bound is durable
                  kind_in              = KIND_REPLAY;
                  pend_counter_in      = value;
                  pend_bound_in        = (value & ~REPLAY_MASK) + REPLAY_BLOCK;
                  result.status        = ST_PERSIST_REPLAY;
                  result.persist_bound = (value & ~REPLAY_MASK) + REPLAY_BLOCK;
               end
            end
            OP_PERSIST_DONE, OP_PERSIST_FAIL: begin
               case (kind_ff)
                  KIND_TX: begin
                     if (op == OP_PERSIST_DONE) begin
                        tx_bound_in   = pend_bound_ff;
                        result.status = ST_ACK;
                     end else begin
                        result.status = ST_REFUSED;
                     end
                     kind_in = KIND_IDLE;
                  end
                  KIND_REPLAY: begin
                     if (op == OP_PERSIST_DONE) begin
                        replay_bound_in = pend_bound_ff;
                        mark_in         = pend_counter_ff;
                        mark_valid_in   = 1'b1;
                        result.status   = ST_RX_ACCEPTED;
                     end else begin
                        result.status = ST_RX_REJECTED;
                     end
                     kind_in = KIND_IDLE;
                  end
                  default: begin
                     result.status = ST_REFUSED;
                  end
               endcase
            end
            OP_LOAD_TX: begin
               if (busy) begin
                  result.status = ST_REFUSED;
               end else begin
                  tx_bound_in   = value;
                  tx_next_in    = value;
                  exhausted_in  = 1'b0;
                  result.status = ST_ACK;
               end
            end
            OP_LOAD_REPLAY: begin
               if (busy) begin
                  result.status = ST_REFUSED;
               end else begin
                  replay_bound_in = value;
                  if (value != '0) begin
                     mark_in       = value - VALUE_W'(1);
                     mark_valid_in = 1'b1;
                  end else begin
                     mark_in       = '0;
                     mark_valid_in = 1'b0;
                  end
                  result.status = ST_ACK;
               end
            end
            default: begin
               result.status = ST_REFUSED;
            end
         endcase
      end
   end

   // Commit the state when the item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_next_ff      <= '0;
         tx_bound_ff     <= '0;
         replay_bound_ff <= '0;
         mark_ff         <= '0;
         mark_valid_ff   <= 1'b0;
         kind_ff         <= KIND_IDLE;
         exhausted_ff    <= 1'b0;
      end else if (fire) begin
         tx_next_ff      <= tx_next_in;
         tx_bound_ff     <= tx_bound_in;
         replay_bound_ff <= replay_bound_in;
         mark_ff         <= mark_in;
         mark_valid_ff   <= mark_valid_in;
         kind_ff         <= kind_in;
         exhausted_ff    <= exhausted_in;
      end
   end

   // Pending bound and counter are read only while a persist is pending
   always_ff @(posedge clock) begin
      if (fire) begin
         pend_bound_ff   <= pend_bound_in;
         pend_counter_ff <= pend_counter_in;
      end
   end

endmodule

// File: src/crrg_checker.sv
// ----------------------------------------------------------------------------
// crrg_checker
// Port-level checks of the guard: response channel behavior across reset and
// stalls, and the zeroing of fields that do not belong to a status.
// ----------------------------------------------------------------------------
module crrg_checker
   import crrg_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [VALUE_W-1:0]   rsp_counter_out,
   input logic [EPOCH_W-1:0]   rsp_epoch_out,
   input logic [VALUE_W-1:0]   rsp_persist_bound
);

   // No response comes out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_counter_out) && $stable(rsp_persist_bound))
      else $error("stalled response changed");

   // Counter and epoch travel only with an issued transmit counter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_TX_ISSUED)
         |-> (rsp_counter_out == '0) && (rsp_epoch_out == '0))
      else $error("counter or epoch set on a non-issue response");

   // Persist bound travels only with a persist request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_PERSIST_TX) && (rsp_status != ST_PERSIST_REPLAY)
         |-> (rsp_persist_bound == '0))
      else $error("persist bound set on a non-persist response");

endmodule

bind counter_reserve_replay_guard_top crrg_checker u_crrg_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the transmit counter reservation and replay guard.
// A scoreboard keeps its own copy of the counters, the pending reservation
// and the two registers, works out the answer to every accepted request and
// compares it field by field with the response stream. Directed requests hit
// the edge cases first; random reservation and receive runs with random gaps
// on both channels follow, across several register settings.
// ----------------------------------------------------------------------------
module tb;
   import crrg_pkg::*;

   // Reservation steps of the guard
   localparam logic [VALUE_W-1:0] TX_STEP = 64'd1024;
   localparam logic [VALUE_W-1:0] RX_STEP = 64'd1024;
   // Request codes outside the defined set
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam int unsigned REPORT_MAX = 10;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrored guard state and the answers still owed
   // -------------------------------------------------------------------------
   class guard_scoreboard;
      result_type awaited_answers[$];
      int unsigned mismatches;
      int unsigned answers_checked;
      int unsigned status_seen[8];

      logic               provisioned;
      logic [EPOCH_W-1:0] cred_epoch;
      logic [VALUE_W-1:0] tx_next;
      logic [VALUE_W-1:0] tx_bound;
      logic [VALUE_W-1:0] replay_bound;
      logic [VALUE_W-1:0] mark;
      logic               mark_ok;
      kind_type           hold_kind;
      logic [VALUE_W-1:0] hold_bound;
      logic [VALUE_W-1:0] hold_counter;
      logic               tx_spent;

      function new();
         mismatches      = 0;
         answers_checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         provisioned  = 1'b0;
         cred_epoch   = '0;
         tx_next      = '0;
         tx_bound     = '0;
         replay_bound = '0;
         mark         = '0;
         mark_ok      = 1'b0;
         hold_kind    = KIND_IDLE;
         hold_bound   = '0;
         hold_counter = '0;
         tx_spent     = 1'b0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_W-1:0] data);
         if (idx == CSR_PROVISIONED) begin
            provisioned = data[0];
         end else begin
            cred_epoch = data[EPOCH_W-1:0];
         end
      endfunction

      // Work out the answer to one request and advance the mirrored state
      function result_type decide_request(input logic [OP_W-1:0] op,
                                          input logic [VALUE_W-1:0] v);
         result_type         ans;
         logic               busy;
         logic [VALUE_W-1:0] rx_top;
         ans        = '0;
         ans.status = ST_REFUSED;
         busy       = (hold_kind != KIND_IDLE);
         rx_top     = ({VALUE_W{1'b1}} / RX_STEP) * RX_STEP;
         if (!provisioned || op > OP_LOAD_REPLAY) return ans;
         case (op)
            OP_TAKE_TX: begin
               if (busy) begin
                  ans.status = ST_REFUSED;
               end else if (tx_spent) begin
                  ans.status = ST_EXHAUSTED;
               end else if (tx_next < tx_bound) begin
                  ans.status  = ST_TX_ISSUED;
                  ans.counter = tx_next;
                  ans.epoch   = cred_epoch;
                  tx_next     = tx_next + 64'd1;
               end else if (tx_bound > {VALUE_W{1'b1}} - TX_STEP) begin
                  tx_spent   = 1'b1;
                  ans.status = ST_EXHAUSTED;
               end else begin
                  hold_kind         = KIND_TX;
                  hold_bound        = tx_bound + TX_STEP;
                  hold_counter      = '0;
                  ans.status        = ST_PERSIST_TX;
                  ans.persist_bound = hold_bound;
               end
            end
            OP_SUBMIT_RX: begin
               if (busy) begin
                  ans.status = ST_REFUSED;
               end else if (mark_ok && v <= mark) begin
                  ans.status = ST_RX_REJECTED;
               end else if (v < replay_bound) begin
                  mark       = v;
                  mark_ok    = 1'b1;
                  ans.status = ST_RX_ACCEPTED;
               end else if (v >= rx_top) begin
                  ans.status = ST_EXHAUSTED;
               end else begin
                  hold_kind         = KIND_REPLAY;
                  hold_counter      = v;
                  hold_bound        = (v / RX_STEP + 64'd1) * RX_STEP;
                  ans.status        = ST_PERSIST_REPLAY;
                  ans.persist_bound = hold_bound;
               end
            end
            OP_PERSIST_DONE, OP_PERSIST_FAIL: begin
               if (hold_kind == KIND_TX) begin
                  if (op == OP_PERSIST_DONE) begin
                     tx_bound   = hold_bound;
                     ans.status = ST_ACK;
                  end else begin
                     ans.status = ST_REFUSED;
                  end
               end else if (hold_kind == KIND_REPLAY) begin
                  if (op == OP_PERSIST_DONE) begin
                     replay_bound = hold_bound;
                     mark         = hold_counter;
                     mark_ok      = 1'b1;
                     ans.status   = ST_RX_ACCEPTED;
                  end else begin
                     ans.status = ST_RX_REJECTED;
                  end
               end
               hold_kind    = KIND_IDLE;
               hold_bound   = '0;
               hold_counter = '0;
            end
            OP_LOAD_TX: begin
               if (!busy) begin
                  tx_bound   = v;
                  tx_next    = v;
                  tx_spent   = 1'b0;
                  ans.status = ST_ACK;
               end
            end
            default: begin
               if (!busy) begin
                  replay_bound = v;
                  mark         = (v != '0) ? v - 64'd1 : '0;
                  mark_ok      = (v != '0);
                  ans.status   = ST_ACK;
               end
            end
         endcase
         return ans;
      endfunction

      function void note_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
         awaited_answers.push_back(decide_request(op, v));
      endfunction

      function void check_response(input logic [STATUS_W-1:0] status,
                                   input logic [VALUE_W-1:0] counter,
                                   input logic [EPOCH_W-1:0] epoch,
                                   input logic [VALUE_W-1:0] bound);
         result_type want;
         answers_checked++;
         if (!$isunknown(status)) status_seen[status]++;
         if (awaited_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("[%0t] response with none awaited: status %0d counter %h",
                        $realtime, status, counter);
            return;
         end
         want = awaited_answers.pop_front();
         if (want.status !== status || want.counter !== counter ||
             want.epoch !== epoch || want.persist_bound !== bound) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("[%0t] response %0d wrong", $realtime, answers_checked);
               $display("   expected status %0d counter %h epoch %h bound %h",
                        want.status, want.counter, want.epoch, want.persist_bound);
               $display("   actual   status %0d counter %h epoch %h bound %h",
                        status, counter, epoch, bound);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block instance
   // -------------------------------------------------------------------------
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op    = '0;
   logic [VALUE_W-1:0]   req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [VALUE_W-1:0]   rsp_counter_out;
   logic [EPOCH_W-1:0]   rsp_epoch_out;
   logic [VALUE_W-1:0]   rsp_persist_bound;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   guard_scoreboard sb;
   logic        req_calm = 1'b0;
   logic        rsp_calm = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned requests_sent = 0;
   int unsigned settings_used = 0;
   logic [VALUE_W-1:0] last_rx_base = '0;

   counter_reserve_replay_guard_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_counter_out   (rsp_counter_out),
      .rsp_epoch_out     (rsp_epoch_out),
      .rsp_persist_bound (rsp_persist_bound),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [VALUE_W-1:0] any_value();
      return {$urandom(), $urandom()};
   endfunction

   // Pick a bound from the interesting regions of the counter space
   function automatic logic [VALUE_W-1:0] pick_bound();
      logic [VALUE_W-1:0] v;
      v = any_value();
      case ($urandom_range(0, 5))
         0: v = 64'($urandom_range(0, 3000));
         1: v = v;
         2: v = '1 - 64'($urandom_range(0, 3000));
         3: v[9:0] = '0;
         4: v = '1 - TX_STEP + 64'($urandom_range(0, 4)) - 64'd2;
         default: v = '1 - 64'd1023 - 64'($urandom_range(0, 2048));
      endcase
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // Monitor: register writes, accepted requests and accepted responses
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) sb.note_request(req_op, req_value);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_status, rsp_counter_out, rsp_epoch_out,
                              rsp_persist_bound);
      end
   end

   // Response side: stall at random unless in a calm stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_hold = idle_span();
         rsp_ready <= (rsp_hold == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------
   task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
      int unsigned gap;
      gap = req_calm ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   // Hold off until every awaited response has come back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [CSR_W-1:0] data);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_directed();
      // refused while no credential is active
      send_item(OP_TAKE_TX, '0);
      write_csr(CSR_PROVISIONED, 32'd1);
      write_csr(CSR_CRED_EPOCH, '1);
      // unknown codes and finish events with nothing pending
      send_item(OP_UNUSED_LO, '1);
      send_item(OP_UNUSED_HI, '0);
      send_item(OP_PERSIST_DONE, '0);
      send_item(OP_PERSIST_FAIL, '1);
      // first take asks for a reservation; others are refused meanwhile
      send_item(OP_TAKE_TX, '0);
      send_item(OP_SUBMIT_RX, '0);
      send_item(OP_LOAD_REPLAY, '1);
      // reservation survives a drop of the credential
      write_csr(CSR_PROVISIONED, 32'd0);
      send_item(OP_PERSIST_DONE, '0);
      write_csr(CSR_PROVISIONED, 32'd1);
      send_item(OP_PERSIST_DONE, '0);
      send_item(OP_TAKE_TX, '1);
      // last reservation that still fits, a failed persist, then a retry
      send_item(OP_LOAD_TX, '1 - TX_STEP);
      send_item(OP_TAKE_TX, '0);
      send_item(OP_PERSIST_FAIL, '0);
      send_item(OP_TAKE_TX, '0);
      send_item(OP_PERSIST_DONE, '0);
      send_item(OP_TAKE_TX, '0);
      // one past that is exhausted until a new bound is loaded
      send_item(OP_LOAD_TX, '1 - TX_STEP + 64'd1);
      send_item(OP_TAKE_TX, '0);
      send_item(OP_TAKE_TX, '0);
      send_item(OP_LOAD_TX, '0);
      // receive side from an empty mark
      send_item(OP_LOAD_REPLAY, '0);
      send_item(OP_SUBMIT_RX, '0);
      send_item(OP_PERSIST_DONE, '0);
      send_item(OP_SUBMIT_RX, '0);
      send_item(OP_SUBMIT_RX, 64'd1023);
      send_item(OP_SUBMIT_RX, 64'd1024);
      send_item(OP_PERSIST_FAIL, '0);
      send_item(OP_SUBMIT_RX, '1);
      send_item(OP_LOAD_REPLAY, '1);
      send_item(OP_SUBMIT_RX, '1 - 64'd1);
      write_csr(CSR_CRED_EPOCH, '0);
   endtask

   // One well-formed run, or a burst of noise now and then
   task automatic run_sequence();
      logic [VALUE_W-1:0] base;
      int unsigned        pick;
      int unsigned        n;
      pick = $urandom_range(0, 19);
      base = pick_bound();
      if (pick < 7) begin
         // transmit: load, reserve, finish, then take counters
         send_item(OP_LOAD_TX, base);
         send_item(OP_TAKE_TX, any_value());
         if ($urandom_range(0, 3) == 0) begin
            send_item(OP_PERSIST_FAIL, any_value());
            send_item(OP_TAKE_TX, any_value());
         end
         send_item(OP_PERSIST_DONE, any_value());
         n = $urandom_range(1, 6);
         repeat (n) send_item(OP_TAKE_TX, any_value());
      end else if (pick < 15) begin
         // receive: counters around the replay bound, some reservations closed
         if ($urandom_range(0, 2) != 0) send_item(OP_LOAD_REPLAY, base);
         else base = last_rx_base;
         n = $urandom_range(2, 8);
         repeat (n) begin
            send_item(OP_SUBMIT_RX, base + 64'($urandom_range(0, 2100)) - 64'd1040);
            if ($urandom_range(0, 2) == 0)
               send_item(($urandom_range(0, 3) == 0) ? OP_PERSIST_FAIL : OP_PERSIST_DONE,
                         any_value());
         end
         last_rx_base = base;
      end else if (pick < 18) begin
         n = $urandom_range(1, 4);
         repeat (n) send_item(OP_W'($urandom_range(0, 7)), any_value());
      end else begin
         // mixed traffic on the current state
         n = $urandom_range(2, 5);
         repeat (n) begin
            if ($urandom_range(0, 1) == 0) send_item(OP_TAKE_TX, any_value());
            else send_item(OP_SUBMIT_RX, last_rx_base + 64'($urandom_range(0, 1500)));
         end
      end
   endtask

   task automatic run_random();
      int                 budget;
      int unsigned        start;
      int unsigned        phase_end;
      logic [CSR_W-1:0]   data;
      budget = 700;
      while (budget > 0) begin
         data    = $urandom();
         data[0] = ($urandom_range(0, 5) != 0);
         write_csr(CSR_PROVISIONED, data);
         case ($urandom_range(0, 3))
            0: write_csr(CSR_CRED_EPOCH, '0);
            1: write_csr(CSR_CRED_EPOCH, '1);
            default: write_csr(CSR_CRED_EPOCH, $urandom());
         endcase
         req_calm = ($urandom_range(0, 4) == 0);
         rsp_calm = ($urandom_range(0, 4) == 0);
         if (!data[0]) begin
            // everything refused; keep these stretches short
            repeat ($urandom_range(5, 12)) send_item(OP_W'($urandom_range(0, 7)), any_value());
         end else begin
            start     = requests_sent;
            phase_end = requests_sent + $urandom_range(40, 100);
            while (requests_sent < phase_end) begin
               if ($urandom_range(0, 24) == 0) wait_quiet();
               run_sequence();
            end
            budget -= int'(requests_sent - start);
         end
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main flow
   // -------------------------------------------------------------------------
   initial begin
      int unsigned waited;
      int unsigned failures;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (sb.awaited_answers.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      failures = sb.mismatches + sb.awaited_answers.size();
      if (sb.awaited_answers.size() != 0)
         $display("%0d responses never arrived", sb.awaited_answers.size());
      $display("Run covered %0d requests over %0d register writes, %0d responses checked.",
               requests_sent, settings_used, sb.answers_checked);
      $display("By status: issued %0d refused %0d accepted %0d rejected %0d persist-tx %0d",
               sb.status_seen[ST_TX_ISSUED], sb.status_seen[ST_REFUSED],
               sb.status_seen[ST_RX_ACCEPTED], sb.status_seen[ST_RX_REJECTED],
               sb.status_seen[ST_PERSIST_TX]);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
src/crrg_pkg.sv
src/crrg_engine.sv
src/counter_reserve_replay_guard_top.sv
src/crrg_checker.sv
tb/tb.sv
